// File: src/fixed_block_pool_allocator_unit_macros.svh
// assertion macros for the block pool allocator checker
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define FBPA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, disabled in reset
`define FBPA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// File: src/fbpa_pkg.sv
// shared constants and types for the block pool allocator
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

    localparam int OFF_W = 21;
    localparam int BS_W  = 13;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    localparam int SLOTS_PER_CHUNK_DEF = 24;
    localparam int MAX_CHUNKS_DEF      = 16;

    localparam logic [BS_W-1:0] MIN_BLOCK = BS_W'(8);
    localparam logic [BS_W-1:0] MAX_BLOCK = BS_W'(4096);

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_OOM      = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_ADDR = 2'd2;

    typedef struct packed {
        logic             done;
        logic             rem_zero;
        logic [OFF_W-1:0] quot;
    } fbpa_div_res_t;

endpackage

`default_nettype wire

// File: src/fbpa_link_ram.sv
// next-slot link store, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module fbpa_link_ram #(
    parameter int DEPTH = 384,
    parameter int AW    = 9,
    parameter int DW    = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/fbpa_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module fbpa_div
    import fbpa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [OFF_W-1:0] dividend,
    input  wire logic [BS_W-1:0]  divisor,
    output fbpa_div_res_t         res
);

    localparam int CNT_W = $clog2(OFF_W + 1);

    logic [OFF_W-1:0] dvd_reg, dvd_next;
    logic [BS_W-1:0]  rem_reg, rem_next;
    logic [BS_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [BS_W:0] shifted;
    logic [BS_W:0] diff;
    logic          ge;

    assign shifted = {rem_reg, dvd_reg[OFF_W-1]};
    assign ge      = shifted >= {1'b0, dsr_reg};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(OFF_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in behind the dividend
            dvd_next = {dvd_reg[OFF_W-2:0], ge};
            rem_next = ge ? diff[BS_W-1:0] : shifted[BS_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign res.done     = done_reg;
    assign res.rem_zero = (rem_reg == '0);
    assign res.quot     = dvd_reg;

endmodule

`default_nettype wire

// File: src/fixed_block_pool_allocator_unit.sv
// block pool allocator top level: sequencer, free-list state and result register
//
//  channel  | signals                          | direction | handshake
//  ---------+----------------------------------+-----------+------------------
//  in       | op, free_offset                  | in        | in_valid/in_stall
//  out      | status, block_offset             | out       | out_valid/out_stall
//  cfg      | block_bytes                      | in        | cfg_valid/cfg_ready
//
//  allocate from a non-empty list: head read from the link store, then pop
//  allocate from an empty list: a new chunk is linked first, one link written per cycle (OOM if none is left)
//  free: the bit-serial divider checks alignment and range before the slot is pushed
//  pool reset: the links of all chunks in use are rewritten as one list from slot 0
//  after reset chunk 0 is linked before the first word is taken
//  one word is in flight at a time; a finished result waits in the output register
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
#(
    parameter int SLOTS_PER_CHUNK = SLOTS_PER_CHUNK_DEF,
    parameter int MAX_CHUNKS      = MAX_CHUNKS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [OP_W-1:0]  op,
    input  wire logic [OFF_W-1:0] free_offset,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic      [ST_W-1:0]  status,
    output logic      [OFF_W-1:0] block_offset,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [BS_W-1:0]  block_bytes
);

    localparam int TOTAL   = SLOTS_PER_CHUNK * MAX_CHUNKS;
    localparam int SLOT_W  = $clog2(TOTAL);
    localparam int PTR_W   = SLOT_W + 1;
    localparam int CHUNK_W = $clog2(MAX_CHUNKS + 1);
    localparam int LINK_W  = SLOT_W + 1;

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SWEEP = 7'b0000100,
        S_RD    = 7'b0001000,
        S_RDW   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_PUT   = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [PTR_W-1:0]   hi_reg, hi_next;
    logic [SLOT_W-1:0]  lo_reg, lo_next;
    logic [SLOT_W-1:0]  head_reg, head_next;
    logic               head_valid_reg, head_valid_next;
    logic [CHUNK_W-1:0] chunks_reg, chunks_next;
    logic [BS_W-1:0]    bs_reg, bs_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [ST_W-1:0]    res_status_reg, res_status_next;
    logic [OFF_W-1:0]   res_offset_reg, res_offset_next;
    logic               out_valid_reg, out_valid_next;
    logic [ST_W-1:0]    status_reg, status_next;
    logic [OFF_W-1:0]   block_offset_reg, block_offset_next;

    logic               in_take;
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    logic [LINK_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [LINK_W-1:0]  ram_rdata;
    logic               div_start;
    fbpa_div_res_t      div_res;

    logic [PTR_W-1:0]   used_limit;
    logic [PTR_W-1:0]   new_lo;
    logic [PTR_W-1:0]   ptr_inc;
    logic               sweep_last;
    logic               head_in_range;
    logic               can_grow;
    logic               free_ok;
    logic [OFF_W-1:0]   pop_offset;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign used_limit    = PTR_W'(chunks_reg) * PTR_W'(SLOTS_PER_CHUNK);
    assign new_lo        = used_limit;
    assign ptr_inc       = ptr_reg + PTR_W'(1);
    assign sweep_last    = (ptr_inc == hi_reg);
    assign head_in_range = ({1'b0, head_reg} < PTR_W'(TOTAL));
    assign can_grow      = (chunks_reg < CHUNK_W'(MAX_CHUNKS));
    assign free_ok       = div_res.rem_zero && (div_res.quot < OFF_W'(used_limit));
    assign pop_offset    = OFF_W'(head_reg) * OFF_W'(bs_reg);

    always_comb
    begin
        bs_next = bs_reg;
        if (cfg_valid && cfg_ready)
        begin
            // slot size clamped to the supported range
            if (block_bytes < MIN_BLOCK)
            begin
                bs_next = MIN_BLOCK;
            end
            else if (block_bytes > MAX_BLOCK)
            begin
                bs_next = MAX_BLOCK;
            end
            else
            begin
                bs_next = block_bytes;
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        ptr_next          = ptr_reg;
        hi_next           = hi_reg;
        lo_next           = lo_reg;
        head_next         = head_reg;
        head_valid_next   = head_valid_reg;
        chunks_next       = chunks_reg;
        op_next           = op_reg;
        res_status_next   = res_status_reg;
        res_offset_next   = res_offset_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        block_offset_next = block_offset_reg;
        ram_we            = 1'b0;
        ram_waddr         = ptr_reg[SLOT_W-1:0];
        ram_wdata         = {sweep_last, ptr_inc[SLOT_W-1:0]};
        ram_re            = 1'b0;
        div_start         = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT, S_SWEEP:
            begin
                // chain one slot to the next, the last one ends the list
                ram_we   = 1'b1;
                ptr_next = ptr_inc;
                if (sweep_last)
                begin
                    head_next       = lo_reg;
                    head_valid_next = 1'b1;
                    if (state_reg == S_INIT)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (op_reg == OP_ALLOC)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    op_next         = op;
                    res_status_next = ST_OK;
                    res_offset_next = '0;
                    case (op)
                        OP_ALLOC:
                        begin
                            if (!head_valid_reg && can_grow)
                            begin
                                lo_next     = new_lo[SLOT_W-1:0];
                                ptr_next    = new_lo;
                                hi_next     = new_lo + PTR_W'(SLOTS_PER_CHUNK);
                                chunks_next = chunks_reg + CHUNK_W'(1);
                                state_next  = S_SWEEP;
                            end
                            else if (head_valid_reg && head_in_range)
                            begin
                                state_next = S_RD;
                            end
                            else
                            begin
                                res_status_next = ST_OOM;
                                state_next      = S_PUT;
                            end
                        end
                        OP_FREE:
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        OP_RESET:
                        begin
                            // relink every chunk in use as one run from slot 0
                            head_valid_next = 1'b0;
                            lo_next         = '0;
                            ptr_next        = '0;
                            hi_next         = used_limit;
                            state_next      = S_SWEEP;
                        end
                        default:
                        begin
                            state_next = S_PUT;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_RDW;
            end
            S_RDW:
            begin
                res_offset_next = pop_offset;
                head_next       = ram_rdata[SLOT_W-1:0];
                head_valid_next = !ram_rdata[LINK_W-1];
                state_next      = S_PUT;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    if (free_ok)
                    begin
                        // push the freed slot in front of the list
                        ram_we          = 1'b1;
                        ram_waddr       = div_res.quot[SLOT_W-1:0];
                        ram_wdata       = {!head_valid_reg, head_reg};
                        head_next       = div_res.quot[SLOT_W-1:0];
                        head_valid_next = 1'b1;
                    end
                    else
                    begin
                        res_status_next = ST_BAD_ADDR;
                    end
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = res_status_reg;
                    block_offset_next = res_offset_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            ptr_reg        <= '0;
            hi_reg         <= PTR_W'(SLOTS_PER_CHUNK);
            lo_reg         <= '0;
            head_reg       <= '0;
            head_valid_reg <= 1'b0;
            chunks_reg     <= CHUNK_W'(1);
            bs_reg         <= MIN_BLOCK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            hi_reg         <= hi_next;
            lo_reg         <= lo_next;
            head_reg       <= head_next;
            head_valid_reg <= head_valid_next;
            chunks_reg     <= chunks_next;
            bs_reg         <= bs_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        res_status_reg   <= res_status_next;
        res_offset_reg   <= res_offset_next;
        status_reg       <= status_next;
        block_offset_reg <= block_offset_next;
    end

    fbpa_link_ram #(
        .DEPTH (TOTAL),
        .AW    (SLOT_W),
        .DW    (LINK_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    fbpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (free_offset),
        .divisor  (bs_reg),
        .res      (div_res)
    );

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign block_offset = block_offset_reg;

endmodule

`default_nettype wire

// File: src/fbpa_checker.sv
// port-level checks for the block pool allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_block_pool_allocator_unit_macros.svh"

module fbpa_checker
    import fbpa_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [ST_W-1:0]  status,
    input wire logic [OFF_W-1:0] block_offset
);

    // a stalled result word stays put
    `FBPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(block_offset))

    `FBPA_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, status == ST_OK || status == ST_OOM || status == ST_BAD_ADDR)

    // failed requests carry no offset
    `FBPA_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && status != ST_OK, block_offset == '0)

    // one word at a time: busy straight after a word is taken
    `FBPA_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .block_offset (block_offset)
);

`default_nettype wire
